@@ sv/fktc_pkg.sv @@
package fktc_pkg;

    // Request kinds carried on s_tuser.
    typedef enum logic [2:0] {
        ACT_SET_VOLT = 3'd0,
        ACT_SET_PCT  = 3'd1,
        ACT_OFF      = 3'd2,
        ACT_TICK     = 3'd3,
        ACT_TACH     = 3'd4
    } action_t;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_VOLT_OFF   = 3'd0,
        REG_VOLT_START = 3'd1,
        REG_VOLT_FULL  = 3'd2,
        REG_DUTY_MIN   = 3'd3,
        REG_KICK_MS    = 3'd4,
        REG_WINDOW_MS  = 3'd5,
        REG_PPR        = 3'd6,
        REG_STALL_MS   = 3'd7
    } cfg_reg_t;

    localparam int unsigned NUM_W  = 48;
    localparam int unsigned DEN_W  = 20;
    localparam int unsigned CNT_W  = 6;
    localparam int unsigned CFG_W  = 16;
    localparam int unsigned IN_W   = 24;
    localparam int unsigned OUT_W  = 40;

    localparam logic [7:0]  DUTY_FULL = 8'd255;
    localparam logic [7:0]  PCT_FULL  = 8'd100;
    localparam logic [15:0] RPM_SCALE = 16'd60000;
    localparam logic [15:0] SAT16     = 16'hFFFF;

    // Reciprocal of 100 scaled by 2^19 and rounded up; exact for products up to 25500.
    localparam logic [12:0] PCT_RECIP = 13'd5243;
    localparam int unsigned PCT_SHIFT = 19;

    // Controller to datapath commands.
    typedef struct packed {
        logic capture;
        logic div_start;
        logic exec;
    } dp_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic need_div;
        logic div_done;
    } dp_sts_t;

endpackage

@@ sv/fktc_div.sv @@
module fktc_div
    import fktc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    output logic              done,
    output logic [NUM_W-1:0]  quot
);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [NUM_W-1:0]   sh_reg, sh_next;
    logic [DEN_W:0]     rem_reg, rem_next;
    logic [DEN_W-1:0]   den_reg, den_next;
    logic [DEN_W:0]     rem_sh;
    logic               fits;

    // One restoring step per cycle, quotient bits shift in at the bottom.
    always_comb
    begin
        rem_sh    = {rem_reg[DEN_W-1:0], sh_reg[NUM_W-1]};
        fits      = rem_sh >= {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W);
            sh_next   = num;
            rem_next  = '0;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? (rem_sh - {1'b0, den_reg}) : rem_sh;
            sh_next  = {sh_reg[NUM_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = sh_reg;

endmodule

@@ sv/fktc_datapath.sv @@
module fktc_datapath
    import fktc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_addr,
    input  logic [CFG_W-1:0]  cfg_wdata,
    input  logic [2:0]        in_action,
    input  logic [IN_W-1:0]   in_data,
    input  dp_cmd_t           cmd,
    output dp_sts_t           sts,
    output logic [OUT_W-1:0]  out_data
);

    // Configuration registers.
    logic [13:0] volt_off_reg, volt_start_reg, volt_full_reg;
    logic [7:0]  duty_min_reg;
    logic [15:0] kick_ms_reg, window_ms_reg, stall_ms_reg;
    logic [3:0]  ppr_reg;

    // Captured request.
    logic [2:0]  act_reg;
    logic [13:0] volt_reg;
    logic [7:0]  pct_reg;

    // Controller state.
    logic [7:0]  applied_reg, applied_next;
    logic        kick_reg, kick_next;
    logic [7:0]  target_reg, target_next;
    logic [15:0] kick_el_reg, kick_el_next;
    logic [31:0] pulse_reg, pulse_next;
    logic [15:0] win_el_reg, win_el_next;
    logic [15:0] rpm_reg, rpm_next;
    logic [15:0] run_reg, run_next;
    logic        ever_reg, ever_next;
    logic [OUT_W-1:0] out_reg, out_next;

    logic [NUM_W-1:0] quot;
    logic [31:0]  mul_a;
    logic [15:0]  mul_b;
    logic [NUM_W-1:0] div_num;
    logic [DEN_W-1:0] div_den;
    logic [15:0]  win_eff, win_inc;
    logic [3:0]   ppr_eff;
    logic [7:0]   pct_c;
    logic [14:0]  pct_prod;
    logic [27:0]  pct_scaled;
    logic [7:0]   pct_duty;
    logic         volt_mid;
    logic         rpm_due;
    logic [7:0]   duty_req;
    logic         req_en, apply_en;
    logic [7:0]   apply_val;
    logic         stall;
    logic         need_div;
    logic         div_done;

    assign win_eff  = (window_ms_reg == '0) ? 16'd1 : window_ms_reg;
    assign ppr_eff  = (ppr_reg == '0) ? 4'd1 : ppr_reg;
    assign win_inc  = (win_el_reg == SAT16) ? SAT16 : win_el_reg + 16'd1;
    assign pct_c    = (pct_reg > PCT_FULL) ? PCT_FULL : pct_reg;
    assign volt_mid = (volt_reg > volt_off_reg) && (volt_reg < volt_full_reg)
                      && (volt_reg > volt_start_reg);
    assign rpm_due  = !kick_reg && (win_inc >= win_eff) && (applied_reg != '0);

    // Percent to duty: scale by 255, then divide by 100 through a reciprocal.
    assign pct_prod   = 15'(pct_c) * 15'(DUTY_FULL);
    assign pct_scaled = 28'(pct_prod) * 28'(PCT_RECIP);
    assign pct_duty   = pct_scaled[PCT_SHIFT+7:PCT_SHIFT];

    assign sts = '{need_div: need_div, div_done: div_done};

    // Division operands: one shared multiplier feeds the numerator.
    always_comb
    begin
        mul_a    = '0;
        mul_b    = '0;
        div_den  = DEN_W'(PCT_FULL);
        need_div = 1'b0;
        unique case (act_reg)
            ACT_SET_VOLT:
            begin
                mul_a    = 32'(volt_reg - volt_start_reg);
                mul_b    = 16'(DUTY_FULL - duty_min_reg);
                div_den  = DEN_W'(volt_full_reg - volt_start_reg);
                need_div = volt_mid;
            end
            ACT_TICK:
            begin
                mul_a    = pulse_reg;
                mul_b    = RPM_SCALE;
                div_den  = DEN_W'(ppr_eff * win_eff);
                need_div = rpm_due;
            end
            default:
            begin
                need_div = 1'b0;
            end
        endcase
        div_num = NUM_W'(mul_a * mul_b);
    end

    fktc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (quot)
    );

    // State update for the captured request.
    always_comb
    begin
        applied_next = applied_reg;
        kick_next    = kick_reg;
        target_next  = target_reg;
        kick_el_next = kick_el_reg;
        pulse_next   = pulse_reg;
        win_el_next  = win_el_reg;
        rpm_next     = rpm_reg;
        run_next     = run_reg;
        ever_next    = ever_reg;
        duty_req     = '0;
        req_en       = 1'b0;
        apply_en     = 1'b0;
        apply_val    = '0;
        unique case (act_reg)
            ACT_SET_VOLT:
            begin
                req_en = 1'b1;
                if (volt_reg <= volt_off_reg)
                    duty_req = '0;
                else if (volt_reg >= volt_full_reg)
                    duty_req = DUTY_FULL;
                else if (volt_reg <= volt_start_reg)
                    duty_req = duty_min_reg;
                else
                    duty_req = duty_min_reg + quot[7:0];
            end
            ACT_SET_PCT:
            begin
                req_en   = 1'b1;
                duty_req = pct_duty;
            end
            ACT_OFF:
            begin
                kick_next = 1'b0;
                apply_en  = 1'b1;
                apply_val = '0;
            end
            ACT_TICK:
            begin
                win_el_next = win_inc;
                if (ever_reg)
                    run_next = (run_reg == SAT16) ? SAT16 : run_reg + 16'd1;
                if (kick_reg)
                begin
                    kick_el_next = (kick_el_reg == SAT16) ? SAT16
                                                          : kick_el_reg + 16'd1;
                    if (kick_el_next >= kick_ms_reg)
                    begin
                        kick_next = 1'b0;
                        apply_en  = 1'b1;
                        apply_val = target_reg;
                    end
                end
                else if (win_inc >= win_eff)
                begin
                    if (applied_reg != '0)
                        rpm_next = (quot[NUM_W-1:16] != '0) ? SAT16 : quot[15:0];
                    else
                        rpm_next = '0;
                    pulse_next  = '0;
                    win_el_next = '0;
                end
            end
            ACT_TACH:
            begin
                if (pulse_reg != '1)
                    pulse_next = pulse_reg + 32'd1;
            end
            default:
            begin
                apply_en = 1'b0;
            end
        endcase

        // Duty request: a start from rest kicks first.
        if (req_en)
        begin
            if (applied_reg == '0 && duty_req != '0 && duty_req != DUTY_FULL
                && !kick_reg)
            begin
                target_next  = duty_req;
                kick_next    = 1'b1;
                kick_el_next = '0;
                apply_en     = 1'b1;
                apply_val    = DUTY_FULL;
            end
            else if (kick_reg && duty_req != '0)
            begin
                target_next = duty_req;
            end
            else
            begin
                apply_en  = 1'b1;
                apply_val = duty_req;
            end
        end

        // Applying a duty.
        if (apply_en)
        begin
            applied_next = apply_val;
            if (apply_val != '0)
            begin
                if (!ever_reg)
                begin
                    run_next  = '0;
                    ever_next = 1'b1;
                end
            end
            else
            begin
                ever_next = 1'b0;
                rpm_next  = '0;
            end
        end

        stall = (applied_next != '0) && ever_next && (run_next >= stall_ms_reg)
                && (rpm_next == '0);
        out_next = {6'd0, stall, kick_next, rpm_next,
                    kick_next ? target_next : applied_next, applied_next};
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volt_off_reg   <= 14'd500;
            volt_start_reg <= 14'd2000;
            volt_full_reg  <= 14'd5000;
            duty_min_reg   <= 8'd80;
            kick_ms_reg    <= 16'd500;
            window_ms_reg  <= 16'd1000;
            ppr_reg        <= 4'd2;
            stall_ms_reg   <= 16'd5000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_VOLT_OFF:   volt_off_reg   <= cfg_wdata[13:0];
                REG_VOLT_START: volt_start_reg <= cfg_wdata[13:0];
                REG_VOLT_FULL:  volt_full_reg  <= cfg_wdata[13:0];
                REG_DUTY_MIN:   duty_min_reg   <= cfg_wdata[7:0];
                REG_KICK_MS:    kick_ms_reg    <= cfg_wdata;
                REG_WINDOW_MS:  window_ms_reg  <= cfg_wdata;
                REG_PPR:        ppr_reg        <= cfg_wdata[3:0];
                REG_STALL_MS:   stall_ms_reg   <= cfg_wdata;
                default:        ppr_reg        <= ppr_reg;
            endcase
        end
    end

    // Controller state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            applied_reg <= '0;
            kick_reg    <= 1'b0;
            target_reg  <= '0;
            kick_el_reg <= '0;
            pulse_reg   <= '0;
            win_el_reg  <= '0;
            rpm_reg     <= '0;
            run_reg     <= '0;
            ever_reg    <= 1'b0;
        end
        else if (cmd.exec)
        begin
            applied_reg <= applied_next;
            kick_reg    <= kick_next;
            target_reg  <= target_next;
            kick_el_reg <= kick_el_next;
            pulse_reg   <= pulse_next;
            win_el_reg  <= win_el_next;
            rpm_reg     <= rpm_next;
            run_reg     <= run_next;
            ever_reg    <= ever_next;
        end
    end

    // Request capture and result register.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg  <= in_action;
            volt_reg <= in_data[13:0];
            pct_reg  <= in_data[21:14];
        end
        if (cmd.exec)
            out_reg <= out_next;
    end

    assign out_data = out_reg;

endmodule

@@ sv/fktc_ctrl.sv @@
module fktc_ctrl
    import fktc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    output logic    s_tready,
    output logic    m_tvalid,
    input  logic    m_tready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PREP = 4'b0010,
        S_DIV  = 4'b0100,
        S_EXEC = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   ovalid_reg, ovalid_next;

    // Sequencing of one request; the result register frees independently.
    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        ovalid_next = ovalid_reg && !m_tready;
        s_tready    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_PREP;
                end
            end
            S_PREP:
            begin
                if (sts.need_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                begin
                    state_next = S_EXEC;
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (!ovalid_reg || m_tready)
                begin
                    cmd.exec    = 1'b1;
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign m_tvalid = ovalid_reg;

endmodule

@@ sv/fan_kickstart_tach_controller_unit.sv @@
// Fan drive controller with kickstart and tachometer. Each beat on the slave
// side carries one request (set voltage, set percent, off, millisecond tick or
// tach pulse) and produces exactly one result beat with the applied duty, the
// intended duty, the measured RPM and the kickstart and stall flags. One
// request at a time is processed: a request that needs no division passes
// from capture through a prepare state to the execute state, which loads the
// result register; a voltage on the linear ramp and a tick that closes a
// measurement window while the fan runs go through a shared restoring divider
// at one quotient bit per cycle before the execute state. A percent request is
// scaled by a constant reciprocal and needs no divider. The next request beat
// can be accepted in the cycle after the result is loaded, and the result
// register lets it be accepted while a result waits.
module fan_kickstart_tach_controller_unit
    import fktc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_addr,
    input  logic [CFG_W-1:0]  cfg_wdata,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [2:0]        s_tuser,   // action
    input  logic [IN_W-1:0]   s_tdata,   // voltage_mv[13:0], percent_in[21:14]
    output logic              m_tvalid,
    input  logic              m_tready,
    // drive_duty[7:0], intended_duty[15:8], fan_rpm[31:16], kick_busy[32],
    // stall_fault[33]
    output logic [OUT_W-1:0]  m_tdata
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    fktc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fktc_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_action (s_tuser),
        .in_data   (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .out_data  (m_tdata)
    );

endmodule

@@ sv/fktc_checker.sv @@
module fktc_checker
    import fktc_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    // A stalled result beat stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    // Without a kickstart the intended duty is the applied duty.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[32] |-> m_tdata[15:8] == m_tdata[7:0])
        else $error("intended duty differs outside kickstart");

    // A stall means the fan is driven and no speed is measured.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[33] |-> m_tdata[31:16] == 16'd0 && m_tdata[7:0] != 8'd0)
        else $error("stall flagged with speed or without drive");

    // An undriven fan reports no speed.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[7:0] == 8'd0 |-> m_tdata[31:16] == 16'd0)
        else $error("speed reported with fan off");

endmodule

bind fan_kickstart_tach_controller_unit fktc_checker u_fktc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ tb/sv/fan_kickstart_tach_controller_unit_test.sv @@
`timescale 1ns / 1ps

module fan_kickstart_tach_controller_unit_test;
    import fktc_pkg::*;

    typedef struct packed {
        logic [7:0]  drive;
        logic [7:0]  intended;
        logic [15:0] rpm;
        logic        kick;
        logic        stall;
    } fan_status_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [2:0]        cfg_addr;
    logic [CFG_W-1:0]  cfg_wdata;
    logic              s_tvalid;
    logic              s_tready;
    logic [2:0]        s_tuser;
    logic [IN_W-1:0]   s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;

    fan_kickstart_tach_controller_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Shadow of the configuration registers.
    logic [13:0] off_mv, start_mv, full_mv;
    logic [7:0]  min_duty;
    logic [15:0] kick_len, window_len, stall_len;
    logic [3:0]  ppr;

    // Shadow of the controller state.
    logic [7:0]  duty_now;
    logic        kicking;
    logic [7:0]  kick_goal;
    logic [15:0] kick_ticks;
    logic [31:0] pulses;
    logic [15:0] window_ticks;
    logic [15:0] rpm_now;
    logic [15:0] run_ticks;
    logic        running;

    fan_status_t status_q[$];
    int          errors;
    bit          no_idle;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic logic [15:0] sat_inc(logic [15:0] x);
        return (x == 16'hFFFF) ? x : x + 16'd1;
    endfunction

    function automatic void apply_duty(logic [7:0] d);
        duty_now = d;
        if (d != 0)
        begin
            if (!running)
            begin
                run_ticks = 0;
                running = 1'b1;
            end
        end
        else
        begin
            running = 1'b0;
            rpm_now = 0;
        end
    endfunction

    function automatic void request_duty(logic [7:0] d);
        if (duty_now == 0 && d > 0 && d < DUTY_FULL && !kicking)
        begin
            kick_goal = d;
            kicking = 1'b1;
            kick_ticks = 0;
            apply_duty(DUTY_FULL);
        end
        else if (kicking && d > 0)
            kick_goal = d;
        else
            apply_duty(d);
    endfunction

    function automatic logic [7:0] duty_for_voltage(logic [13:0] v);
        int unsigned span;
        if (v <= off_mv)
            return 8'd0;
        if (v >= full_mv)
            return DUTY_FULL;
        if (v <= start_mv)
            return min_duty;
        span = (int'(v) - int'(start_mv)) * (255 - int'(min_duty)) / (full_mv - start_mv);
        return min_duty + span[7:0];
    endfunction

    function automatic void advance_ms();
        longint unsigned win;
        longint unsigned per_rev;
        longint unsigned r;
        window_ticks = sat_inc(window_ticks);
        if (running)
            run_ticks = sat_inc(run_ticks);
        if (kicking)
        begin
            kick_ticks = sat_inc(kick_ticks);
            if (kick_ticks >= kick_len)
            begin
                kicking = 1'b0;
                apply_duty(kick_goal);
            end
        end
        else
        begin
            win = (window_len == 0) ? 1 : window_len;
            if (window_ticks >= win)
            begin
                if (duty_now > 0)
                begin
                    per_rev = (ppr == 0) ? 1 : ppr;
                    r = (longint'(pulses) * 60000) / (per_rev * win);
                    rpm_now = (r > 65535) ? 16'hFFFF : r[15:0];
                end
                else
                    rpm_now = 0;
                pulses = 0;
                window_ticks = 0;
            end
        end
    endfunction

    // Advance the shadow state by one request and queue the status it yields.
    function automatic void predict_status(logic [2:0] act, logic [13:0] v, logic [7:0] p);
        fan_status_t s;
        int unsigned pc;
        case (act)
            ACT_SET_VOLT: request_duty(duty_for_voltage(v));
            ACT_SET_PCT:
            begin
                pc = (p > PCT_FULL) ? 100 : p;
                request_duty(8'(pc * 255 / 100));
            end
            ACT_OFF:
            begin
                kicking = 1'b0;
                apply_duty(8'd0);
            end
            ACT_TICK: advance_ms();
            ACT_TACH:
                if (pulses != 32'hFFFF_FFFF)
                    pulses = pulses + 1;
            default: ;
        endcase
        s.drive = duty_now;
        s.intended = kicking ? kick_goal : duty_now;
        s.rpm = rpm_now;
        s.kick = kicking;
        s.stall = (duty_now != 0 && running && run_ticks >= stall_len && rpm_now == 0);
        status_q.push_back(s);
    endfunction

    // Send one request beat; valid stays high if the next beat follows at once.
    task automatic send_request(logic [2:0] act, logic [13:0] v, logic [7:0] p);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= {2'b00, p, v};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_status(act, v, p);
        gap = no_idle ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop valid and let every outstanding result drain.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (status_q.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_VOLT_OFF:   off_mv = val[13:0];
            REG_VOLT_START: start_mv = val[13:0];
            REG_VOLT_FULL:  full_mv = val[13:0];
            REG_DUTY_MIN:   min_duty = val[7:0];
            REG_KICK_MS:    kick_len = val;
            REG_WINDOW_MS:  window_len = val;
            REG_PPR:        ppr = val[3:0];
            REG_STALL_MS:   stall_len = val;
            default: ;
        endcase
    endtask

    task automatic load_config(int o, int st, int f, int dm, int k, int w, int pp, int sd);
        drain();
        write_reg(REG_VOLT_OFF, 16'(o));
        write_reg(REG_VOLT_START, 16'(st));
        write_reg(REG_VOLT_FULL, 16'(f));
        write_reg(REG_DUTY_MIN, 16'(dm));
        write_reg(REG_KICK_MS, 16'(k));
        write_reg(REG_WINDOW_MS, 16'(w));
        write_reg(REG_PPR, 16'(pp));
        write_reg(REG_STALL_MS, 16'(sd));
    endtask

    // Voltage map at the band edges, including the top code.
    task automatic test_voltage_map();
        send_request(ACT_SET_VOLT, 14'd0, 8'd0);
        send_request(ACT_SET_VOLT, 14'd3000, 8'd0);
        send_request(ACT_SET_VOLT, 14'd1999, 8'd0);
        send_request(ACT_SET_VOLT, 14'd16383, 8'd0);
        send_request(ACT_SET_VOLT, 14'd500, 8'd0);
        send_request(ACT_SET_VOLT, 14'd4999, 8'hFF);
    endtask

    // Percent map with clamping, off and unknown requests.
    task automatic test_percent_map();
        send_request(ACT_OFF, 14'h3FFF, 8'hFF);
        send_request(ACT_SET_PCT, 14'd0, 8'd100);
        send_request(ACT_SET_PCT, 14'd0, 8'd255);
        send_request(ACT_SET_PCT, 14'd0, 8'd0);
        send_request(3'(ACT_TACH + 1), 14'h3FFF, 8'hFF);
        send_request(3'(ACT_TACH + 3), 14'd0, 8'd0);
    endtask

    // Kickstart from rest, retarget and zero request during the burst.
    task automatic test_kickstart();
        send_request(ACT_SET_PCT, 14'd0, 8'd1);
        send_request(ACT_SET_PCT, 14'd0, 8'd50);
        send_request(ACT_TICK, 14'd0, 8'd0);
        send_request(ACT_SET_VOLT, 14'd0, 8'd0);
        send_request(ACT_TICK, 14'd0, 8'd0);
        send_request(ACT_TICK, 14'd0, 8'd0);
    endtask

    // RPM measurement, then stall with no pulses.
    task automatic test_tach_and_stall();
        send_request(ACT_TACH, 14'd0, 8'd0);
        send_request(ACT_TACH, 14'd0, 8'd0);
        send_request(ACT_TICK, 14'd0, 8'd0);
        send_request(ACT_TICK, 14'd0, 8'd0);
        send_request(ACT_TICK, 14'd0, 8'd0);
        send_request(ACT_TICK, 14'd0, 8'd0);
    endtask

    task automatic random_phase(int n);
        int r;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 49) == 0)
                no_idle = !no_idle;
            r = $urandom_range(0, 99);
            if (r < 45)
                send_request(ACT_TICK, 14'($urandom), 8'($urandom));
            else if (r < 70)
                send_request(ACT_TACH, 14'($urandom), 8'($urandom));
            else if (r < 82)
                send_request(ACT_SET_VOLT, 14'($urandom), 8'($urandom));
            else if (r < 92)
                send_request(ACT_SET_PCT, 14'($urandom), 8'($urandom));
            else if (r < 97)
                send_request(ACT_OFF, 14'($urandom), 8'($urandom));
            else
                send_request(3'($urandom_range(ACT_TACH + 1, 7)), 14'($urandom),
                             8'($urandom));
        end
    endtask

    // Random traffic over several settings, the extremes first.
    task automatic test_random();
        int a, b, c, t;
        load_config(0, 0, 0, 0, 0, 0, 0, 0);
        random_phase(200);
        load_config(16383, 16383, 16383, 255, 65535, 65535, 15, 65535);
        random_phase(100);
        load_config(0, 0, 16383, 255, 1, 1, 1, 0);
        random_phase(200);
        for (int ph = 0; ph < 6; ph++)
        begin
            a = $urandom_range(0, 16383);
            b = $urandom_range(0, 16383);
            c = $urandom_range(0, 16383);
            if (ph < 4)
            begin
                if (a > b) begin t = a; a = b; b = t; end
                if (b > c) begin t = b; b = c; c = t; end
                if (a > b) begin t = a; a = b; b = t; end
            end
            load_config(a, b, c, $urandom_range(0, 255), $urandom_range(0, 6),
                        $urandom_range(0, 20), $urandom_range(0, 8),
                        $urandom_range(0, 40));
            random_phase(230);
        end
    endtask

    // Result checker with random back-pressure.
    initial
    begin
        fan_status_t got;
        fan_status_t want;
        int st;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            st = no_idle ? 0 : $urandom_range(0, 14);
            if (st > 0)
            begin
                m_tready <= 1'b0;
                repeat (st) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            got.drive = m_tdata[7:0];
            got.intended = m_tdata[15:8];
            got.rpm = m_tdata[31:16];
            got.kick = m_tdata[32];
            got.stall = m_tdata[33];
            if (status_q.size() == 0)
            begin
                $display("%0t: unexpected result beat %h", $time, m_tdata);
                errors++;
            end
            else
            begin
                want = status_q.pop_front();
                if (got.drive !== want.drive)
                begin
                    $display("%0t: drive_duty expected %0d actual %0d", $time, want.drive,
                             got.drive);
                    errors++;
                end
                if (got.intended !== want.intended)
                begin
                    $display("%0t: intended_duty expected %0d actual %0d", $time,
                             want.intended, got.intended);
                    errors++;
                end
                if (got.rpm !== want.rpm)
                begin
                    $display("%0t: fan_rpm expected %0d actual %0d", $time, want.rpm, got.rpm);
                    errors++;
                end
                if (got.kick !== want.kick)
                begin
                    $display("%0t: kick_busy expected %0d actual %0d", $time, want.kick,
                             got.kick);
                    errors++;
                end
                if (got.stall !== want.stall)
                begin
                    $display("%0t: stall_fault expected %0d actual %0d", $time, want.stall,
                             got.stall);
                    errors++;
                end
            end
        end
    end

    // Main sequence.
    initial
    begin
        errors = 0;
        no_idle = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = REG_VOLT_OFF;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tuser = ACT_TICK;
        s_tdata = '0;
        off_mv = 500;
        start_mv = 2000;
        full_mv = 5000;
        min_duty = 80;
        kick_len = 500;
        window_len = 1000;
        ppr = 2;
        stall_len = 5000;
        duty_now = 0;
        kicking = 0;
        kick_goal = 0;
        kick_ticks = 0;
        pulses = 0;
        window_ticks = 0;
        rpm_now = 0;
        run_ticks = 0;
        running = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_voltage_map();
        test_percent_map();
        load_config(500, 2000, 5000, 80, 2, 2, 1, 3);
        test_kickstart();
        test_tach_and_stall();
        test_random();
        drain();
        if (errors == 0)
            $display("PASS fan_kickstart_tach_controller_unit");
        else
            $display("FAIL fan_kickstart_tach_controller_unit");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #50_000_000;
        $display("FAIL fan_kickstart_tach_controller_unit");
        $finish;
    end

endmodule
